>>> design/edu_pkg.sv
// Shared types and constants for the edit distance unit.
package edu_pkg;

  localparam int unsigned DW = 8;
  localparam int unsigned MAX_CAND_LEN = 255;
  localparam logic [DW-1:0] CAND_LIMIT =
      (MAX_CAND_LEN > 255) ? 8'd255 : DW'(MAX_CAND_LEN);
  localparam logic [DW-1:0] DIST_MAX = 8'hFF;

  localparam logic [1:0] REG_QUERY_LENGTH = 2'd0;
  localparam logic [1:0] REG_QUERY_LOW    = 2'd1;
  localparam logic [1:0] REG_QUERY_HIGH   = 2'd2;

  // One candidate item as it moves along the row of cells.
  typedef struct packed {
    logic          vld;
    logic          upd;
    logic [DW-1:0] ch;
    logic          last;
    logic          ovf;
    logic [DW-1:0] score;
  } edu_tok_t;

endpackage

>>> design/edu_head.sv
// Front stage: candidate byte counter, overflow tracking and column zero.
module edu_head import edu_pkg::*; (
  input  logic          clk,
  input  logic          rst,
  input  logic          clr,
  input  logic          adv,
  input  logic          acc,
  input  logic [DW-1:0] cand_byte,
  input  logic          byte_valid,
  input  logic          last_byte,
  output edu_tok_t      tok_out,
  output logic [DW-1:0] left_out,
  output logic [DW-1:0] diag_out
);

  logic [DW-1:0] cnt;
  logic          ovf_seen;
  logic          take;
  logic          over;
  logic          upd;
  logic [DW-1:0] cnt_next;
  logic          ovf_next;

  always_comb begin
    take     = acc & byte_valid & ~ovf_seen;
    over     = take & (cnt >= CAND_LIMIT);
    upd      = take & ~over;
    cnt_next = upd ? cnt + 8'd1 : cnt;
    ovf_next = ovf_seen | over;
  end

  always_ff @(posedge clk) begin
    if (rst || clr) begin
      cnt         <= '0;
      ovf_seen    <= 1'b0;
      tok_out.vld <= 1'b0;
    end else if (adv) begin
      tok_out.vld   <= acc;
      tok_out.upd   <= upd;
      tok_out.ch    <= cand_byte;
      tok_out.last  <= last_byte;
      tok_out.ovf   <= ovf_next;
      tok_out.score <= cnt_next;
      left_out      <= cnt_next;
      diag_out      <= cnt;
      if (acc && last_byte) begin
        cnt      <= '0;
        ovf_seen <= 1'b0;
      end else begin
        cnt      <= cnt_next;
        ovf_seen <= ovf_next;
      end
    end
  end

endmodule

>>> design/edu_cell.sv
// One cell of the distance row: holds the entry for one query prefix.
module edu_cell import edu_pkg::*; #(
  parameter int unsigned IDX = 1,
  parameter int unsigned LW  = 5
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          clr,
  input  logic          adv,
  input  logic [LW-1:0] eff_len,
  input  logic [DW-1:0] qbyte,
  input  edu_tok_t      tok_in,
  input  logic [DW-1:0] left_in,
  input  logic [DW-1:0] diag_in,
  output edu_tok_t      tok_out,
  output logic [DW-1:0] left_out,
  output logic [DW-1:0] diag_out
);

  localparam logic [DW-1:0] INIT = DW'(IDX);

  logic [DW-1:0] d;
  logic [DW-1:0] m;
  logic [DW-1:0] nv;
  logic          upd;
  logic [DW-1:0] after;
  edu_tok_t      tok_next;

  always_comb begin
    m = (d < left_in) ? d : left_in;
    m = (diag_in < m) ? diag_in : m;
    if (tok_in.ch == qbyte) begin
      nv = diag_in;
    end else begin
      nv = (m == DIST_MAX) ? DIST_MAX : m + 8'd1;
    end
    upd   = tok_in.vld & tok_in.upd;
    after = upd ? nv : d;
    tok_next = tok_in;
    if (eff_len == LW'(IDX)) begin
      tok_next.score = after;
    end
  end

  always_ff @(posedge clk) begin
    if (rst || clr) begin
      d           <= INIT;
      tok_out.vld <= 1'b0;
    end else if (adv) begin
      tok_out  <= tok_next;
      left_out <= after;
      diag_out <= d;
      // The last item of a word leaves the entry ready for the next word.
      if (tok_in.vld && tok_in.last) begin
        d <= INIT;
      end else begin
        d <= after;
      end
    end
  end

endmodule

>>> design/edit_distance_unit_core.sv
// Top level of the edit distance unit: configuration, cell row and output register.
//
// Levenshtein distance between a configured query word (up to MAX_QUERY_LEN
// bytes) and a stream of candidate words. The query is set on the cfg port:
// index 0 is the query length, 1 and 2 hold query bytes 0..7 and 8..15.
// A write to index 0, 1 or 2 restarts the current word; write only while the block is idle.
// Input s_*: one candidate byte per transfer, tuser[0] flags a real byte,
// tlast ends the word. A word with no bytes is a single transfer with
// tuser[0] low and tlast high.
// Output m_*: one transfer per word, carrying the distance; tuser[0] is set
// when the word exceeded 255 bytes, and the distance then reads 255.
// Throughput: one byte per cycle while the output is not stalled. The byte
// ripples from the head stage down a row of MAX_QUERY_LEN cells, and the
// result for a word is then held in the output register.
// When the receiver holds m_tready low with a result waiting, the whole row
// stalls and s_tready drops. Reset clears the row to 0..n, the query to
// empty and the output valid flag.
module edit_distance_unit_core import edu_pkg::*; #(
  parameter int unsigned MAX_QUERY_LEN = 16
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          cfg_we,
  input  logic [1:0]    cfg_index,
  input  logic [63:0]   cfg_data,
  input  logic          s_tvalid,
  output logic          s_tready,
  input  logic [7:0]    s_tdata,   // [7:0] cand_byte
  input  logic [0:0]    s_tuser,   // [0] byte_valid
  input  logic          s_tlast,   // last_byte
  output logic          m_tvalid,
  input  logic          m_tready,
  output logic [7:0]    m_tdata,   // [7:0] edit_distance
  output logic [0:0]    m_tuser    // [0] length_overflow
);

  localparam int unsigned N  = MAX_QUERY_LEN;
  localparam int unsigned LW = $clog2(N + 1);

  logic [LW-1:0] eff_len;
  logic [63:0]   qlo;
  logic [63:0]   qhi;
  logic          clr;
  logic          adv;
  logic          acc;

  edu_tok_t      tok  [0:N];
  logic [DW-1:0] left [0:N];
  logic [DW-1:0] diag [0:N];

  assign clr      = cfg_we && (cfg_index == REG_QUERY_LENGTH ||
                               cfg_index == REG_QUERY_LOW ||
                               cfg_index == REG_QUERY_HIGH);
  assign adv      = ~m_tvalid | m_tready;
  assign s_tready = adv;
  assign acc      = s_tvalid & adv;

  always_ff @(posedge clk) begin
    if (rst) begin
      eff_len <= '0;
      qlo     <= '0;
      qhi     <= '0;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_QUERY_LENGTH: begin
          // Lengths above the row size are clamped.
          if ({1'b0, cfg_data[4:0]} > 6'(N)) begin
            eff_len <= LW'(N);
          end else begin
            eff_len <= LW'(cfg_data[4:0]);
          end
        end
        REG_QUERY_LOW:  qlo <= cfg_data;
        REG_QUERY_HIGH: qhi <= cfg_data;
        default: ;
      endcase
    end
  end

  edu_head u_head (
    .clk        (clk),
    .rst        (rst),
    .clr        (clr),
    .adv        (adv),
    .acc        (acc),
    .cand_byte  (s_tdata),
    .byte_valid (s_tuser[0]),
    .last_byte  (s_tlast),
    .tok_out    (tok[0]),
    .left_out   (left[0]),
    .diag_out   (diag[0])
  );

  for (genvar j = 1; j <= N; j++) begin : g_cell
    logic [DW-1:0] qb;
    if (j - 1 < 8) begin : g_lo
      assign qb = qlo[8*(j-1) +: 8];
    end else if (j - 1 < 16) begin : g_hi
      assign qb = qhi[8*(j-9) +: 8];
    end else begin : g_zero
      assign qb = '0;
    end

    edu_cell #(.IDX(j), .LW(LW)) u_cell (
      .clk      (clk),
      .rst      (rst),
      .clr      (clr),
      .adv      (adv),
      .eff_len  (eff_len),
      .qbyte    (qb),
      .tok_in   (tok[j-1]),
      .left_in  (left[j-1]),
      .diag_in  (diag[j-1]),
      .tok_out  (tok[j]),
      .left_out (left[j]),
      .diag_out (diag[j])
    );
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (adv) begin
      m_tvalid   <= tok[N].vld & tok[N].last;
      m_tdata    <= tok[N].ovf ? DIST_MAX : tok[N].score;
      m_tuser[0] <= tok[N].ovf;
    end
  end

endmodule

>>> design/edu_checker.sv
// Port-level checks for the edit distance unit, bound to the top level.
module edu_port_checker (
  input logic       clk,
  input logic       rst,
  input logic       s_tready,
  input logic       m_tvalid,
  input logic       m_tready,
  input logic [7:0] m_tdata,
  input logic [0:0] m_tuser
);

  a_reset_idle: assert property (@(posedge clk) rst |=> !m_tvalid)
    else $error("result shown right after reset");

  a_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
    else $error("stalled result changed");

  a_ovf_sat: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tuser[0] |-> m_tdata == 8'hFF)
    else $error("overflowed word without saturated distance");

  a_stall_in: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |-> !s_tready)
    else $error("input taken while the row is stalled");

endmodule

bind edit_distance_unit_core edu_port_checker u_edu_checker (
  .clk      (clk),
  .rst      (rst),
  .s_tready (s_tready),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata),
  .m_tuser  (m_tuser)
);
